>>> rtl/hwti_pkg.sv
`timescale 1ns / 1ps

package hwti_pkg;

  localparam int HASH_W    = 32;
  localparam int BYTE_W    = 8;
  localparam int VEC_W     = 200;
  localparam int SLOT_OUT_W = 10;
  localparam int DIV_CNT_W = 5;
  localparam int MIX_SHIFT = 5;

  localparam logic [HASH_W-1:0] HASH_START = 32'd5381;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DIV,
    ST_READ,
    ST_CHECK
  } state_t;

  // djb2 step: hash*33 plus the byte read as signed, zero bytes are padding
  function automatic logic [HASH_W-1:0] mix_byte(input logic [HASH_W-1:0] h,
                                                 input logic [BYTE_W-1:0] b);
    logic [HASH_W-1:0] ext;
    ext = {{(HASH_W-BYTE_W){b[BYTE_W-1]}}, b};
    if (b == '0) begin
      return h;
    end
    return (h << MIX_SHIFT) + h + ext;
  endfunction

endpackage

>>> rtl/hashed_word_table_insert_core.sv
`timescale 1ns / 1ps
// a word takes WORD_BYTES transactions, one byte per cycle while busy is low; done is registered
//   from ST_CHECK, reached straight after the final byte when SLOTS is a power of two, else
//   after a three-step reciprocal remainder of the 32-bit hash (ST_DIV) and a table read (ST_READ)
// busy stays high after the final byte until the result is out, so the next word waits for it
// reset: after rst the word table is swept clear, one slot per cycle, with busy high
// results are shown for one cycle on done; the receiver cannot stall them
module hashed_word_table_insert_core #(
  parameter int SLOTS      = 1024,
  parameter int WORD_BYTES = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [hwti_pkg::BYTE_W-1:0]     word_byte,
  input  logic [63:0]                     vector_w0,
  input  logic [63:0]                     vector_w1,
  input  logic [63:0]                     vector_w2,
  input  logic [7:0]                      vector_top,
  output logic                            done,
  output logic [hwti_pkg::HASH_W-1:0]     hash_value,
  output logic [hwti_pkg::SLOT_OUT_W-1:0] slot_index,
  output logic                            inserted
);
  import hwti_pkg::*;

  localparam int  SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int  POS_W   = (WORD_BYTES > 1) ? $clog2(WORD_BYTES) : 1;
  localparam int  ROW_W   = WORD_BYTES * BYTE_W;
  localparam bit  IS_POW2 = ((SLOTS & (SLOTS - 1)) == 0);
  localparam logic [SLOT_W:0]    SLOTS_V  = (SLOT_W + 1)'(SLOTS);
  localparam logic [SLOT_W-1:0]  LAST_IDX = SLOT_W'(SLOTS - 1);
  localparam logic [POS_W-1:0]   LAST_POS = POS_W'(WORD_BYTES - 1);
  localparam logic [DIV_CNT_W-1:0] DIV_TOP = DIV_CNT_W'(2);
  localparam logic [HASH_W-1:0]  RECIP    = HASH_W'((64'd1 << HASH_W) / SLOTS);

  state_t state, state_next;

  logic [SLOT_W-1:0]    clr_idx;
  logic [POS_W-1:0]     pos;
  logic [HASH_W-1:0]    run_hash;
  logic [BYTE_W-1:0]    word_buf [WORD_BYTES];
  logic [VEC_W-1:0]     vec;
  logic [HASH_W-1:0]    hash_reg;
  logic [SLOT_W-1:0]    slot_reg;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [HASH_W-1:0]    quo;
  logic [SLOT_W:0]      rem_reg;
  logic [ROW_W-1:0]     rd_row;

  logic [ROW_W-1:0]     word_mem [SLOTS];
  logic [VEC_W-1:0]     vec_mem  [SLOTS];

  logic                 accept;
  logic                 last_byte;
  logic [HASH_W-1:0]    hash_next;
  logic [HASH_W-1:0]    quo_next;
  logic [SLOT_W:0]      qs_low;
  logic [SLOT_W:0]      rem_calc;
  logic [SLOT_W:0]      rem_next;
  logic [SLOT_W-1:0]    rd_addr;
  logic [SLOT_W-1:0]    wr_addr;
  logic [ROW_W-1:0]     wr_row;
  logic [ROW_W-1:0]     word_row;
  logic                 slot_empty;
  logic                 word_we;
  logic                 vec_we;

  assign accept    = start && !busy;
  assign last_byte = (pos == LAST_POS);
  assign hash_next = mix_byte(run_hash, word_byte);

  // quotient estimate from the reciprocal is low by at most one, so one subtract fixes it
  assign quo_next = HASH_W'(({{HASH_W{1'b0}}, hash_reg} * {{HASH_W{1'b0}}, RECIP}) >> HASH_W);
  assign qs_low   = quo[SLOT_W:0] * SLOTS_V;
  assign rem_calc = hash_reg[SLOT_W:0] - qs_low;
  assign rem_next = (rem_reg >= SLOTS_V) ? (rem_reg - SLOTS_V) : rem_reg;

  always_comb begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      word_row[i*BYTE_W +: BYTE_W] = word_buf[i];
    end
  end

  assign slot_empty = (rd_row[BYTE_W-1:0] == '0);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (clr_idx == LAST_IDX) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept && last_byte) state_next = IS_POW2 ? ST_CHECK : ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt == '0) state_next = ST_READ;
      end
      ST_READ:  state_next = ST_CHECK;
      ST_CHECK: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  // outputs and memory controls
  always_comb begin
    busy    = 1'b1;
    word_we = 1'b0;
    vec_we  = 1'b0;
    wr_addr = slot_reg;
    wr_row  = word_row;
    rd_addr = slot_reg;
    unique case (state)
      ST_CLEAR: begin
        word_we = 1'b1;
        wr_addr = clr_idx;
        wr_row  = '0;
      end
      ST_IDLE: begin
        busy    = 1'b0;
        rd_addr = hash_next[SLOT_W-1:0];
      end
      ST_DIV, ST_READ: begin
      end
      ST_CHECK: begin
        word_we = slot_empty;
        vec_we  = slot_empty;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_idx  <= '0;
      pos      <= '0;
      run_hash <= HASH_START;
      done     <= 1'b0;
    end else begin
      state <= state_next;
      done  <= 1'b0;
      unique case (state)
        ST_CLEAR: begin
          clr_idx <= clr_idx + 1'b1;
        end
        ST_IDLE: begin
          if (accept) begin
            word_buf[pos] <= word_byte;
            if (last_byte) begin
              hash_reg <= hash_next;
              run_hash <= HASH_START;
              pos      <= '0;
              vec      <= {vector_top, vector_w2, vector_w1, vector_w0};
              slot_reg <= IS_POW2 ? hash_next[SLOT_W-1:0] : '0;
              div_cnt  <= DIV_TOP;
            end else begin
              run_hash <= hash_next;
              pos      <= pos + 1'b1;
            end
          end
        end
        ST_DIV: begin
          // three-stage pipeline, hash_reg holds still so all stages settle by the last step
          quo      <= quo_next;
          rem_reg  <= rem_calc;
          slot_reg <= rem_next[SLOT_W-1:0];
          div_cnt  <= div_cnt - 1'b1;
        end
        ST_READ: begin
        end
        ST_CHECK: begin
          done       <= 1'b1;
          hash_value <= hash_reg;
          slot_index <= SLOT_OUT_W'(slot_reg);
          inserted   <= slot_empty;
        end
        default: begin
        end
      endcase
    end
  end

  // word table: first occupant wins, so only the first byte of the row is tested
  always_ff @(posedge clk) begin
    if (word_we) begin
      word_mem[wr_addr] <= wr_row;
    end
    rd_row <= word_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (vec_we) begin
      vec_mem[slot_reg] <= vec;
    end
  end

endmodule
